// ----- rtl/core/tafe_pkg.sv -----
// ----------------------------------------------------------------------------
// tafe_pkg
// Shared types and constants of the trimmed ascii field extract unit.
// ----------------------------------------------------------------------------
package tafe_pkg;

    // input transaction payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_payload;
    } tafe_in_t;

    // result transaction payload
    typedef struct packed {
        logic [6:0] out_char;
        logic       char_valid;
        logic       field_done;
        logic [5:0] field_length;
    } tafe_out_t;

    // configuration register indexes
    localparam logic [1:0] REG_FIELD_START = 2'd0;
    localparam logic [1:0] REG_FIELD_END   = 2'd1;
    localparam logic [1:0] REG_DEST_SIZE   = 2'd2;

    // register reset values
    localparam logic [7:0] FIELD_START_RST = 8'd0;
    localparam logic [7:0] FIELD_END_RST   = 8'd29;
    localparam logic [6:0] DEST_SIZE_RST   = 7'd32;

    // character codes and limits
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [6:0] MAX_EMIT   = 7'd63;
    localparam logic [5:0] PEND_MAX   = 6'd63;
    localparam logic [7:0] POS_MAX    = 8'd255;

endpackage

// ----- rtl/core/trimmed_ascii_field_extract_unit.sv -----
// ----------------------------------------------------------------------------
// trimmed_ascii_field_extract_unit
// Extracts a trimmed printable field from a byte stream, one character per
// result transaction, followed by a closing transaction with the length.
// ----------------------------------------------------------------------------
// An input transaction is accepted in the idle state and, while the field is
// open, then evaluated; one that causes no result returns to idle, and one that
// only closes the field goes on to the close state. A visible character then
// passes through the space flush, which emits the pending spaces one at a
// time, and then emits its own character, followed by the close when it also
// closes the field. Once the output limit is reached the remaining pending
// spaces are dropped all at once. Each cycle that loads the output register
// waits while that register still holds a result that has not been accepted.
// The pace is set by the single output register, which carries one result per
// cycle while the receiver takes them, and by the small sequencer that walks
// the pending space count down one space at a time. s_ready is low while an
// item is in work. The configuration port is always ready.
module trimmed_ascii_field_extract_unit #(
    parameter int SCRATCH_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tafe_pkg::tafe_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tafe_pkg::tafe_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import tafe_pkg::*;

    localparam int KW = (SCRATCH_DEPTH > 2) ? $clog2(SCRATCH_DEPTH) : 1;
    localparam logic [KW-1:0] KEPT_MAX = KW'(SCRATCH_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH,
        ST_CHAR,
        ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] field_start_reg, field_end_reg;
    logic [6:0] dest_size_reg;

    logic [7:0]    position_reg, position_next;
    logic [KW-1:0] kept_reg, kept_next;
    logic [5:0]    pend_reg, pend_next;
    logic          started_reg, started_next;
    logic [5:0]    emitted_reg, emitted_next;
    logic          finished_reg, finished_next;

    logic [7:0] byte_reg, byte_next;
    logic       eop_reg, eop_next;
    logic       close_reg, close_next;

    logic       m_valid_reg, m_valid_next;
    tafe_out_t  m_data_reg, m_data_next;

    logic       out_free;
    logic [6:0] lim_raw, lim;
    logic       room;
    logic       in_field, printable;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // output register slot is free this cycle
    assign out_free = !m_valid_reg || m_ready;

    // emit limit: dest_size - 1 (0 for a size of 0), capped at 63
    assign lim_raw = (dest_size_reg == 7'd0) ? 7'd0 : dest_size_reg - 7'd1;
    assign lim     = (lim_raw > MAX_EMIT) ? MAX_EMIT : lim_raw;
    assign room    = ({1'b0, emitted_reg} < lim);

    // classification of the held byte
    assign in_field  = (position_reg >= field_start_reg) && (position_reg <= field_end_reg)
                       && (kept_reg < KEPT_MAX);
    assign printable = (byte_reg >= CHAR_SPACE) && (byte_reg < CHAR_DEL);

    // sequencer next state
    always_comb begin
        state_next    = state_reg;
        position_next = position_reg;
        kept_next     = kept_reg;
        pend_next     = pend_reg;
        started_next  = started_reg;
        emitted_next  = emitted_reg;
        finished_next = finished_reg;
        byte_next     = byte_reg;
        eop_next      = eop_reg;
        close_next    = close_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next = s_data.in_byte;
                    eop_next  = s_data.end_of_payload;
                    if (finished_reg) begin
                        // field already closed: only re-arm on end of payload
                        if (s_data.end_of_payload) begin
                            position_next = 8'd0;
                            kept_next     = '0;
                            pend_next     = 6'd0;
                            started_next  = 1'b0;
                            emitted_next  = 6'd0;
                            finished_next = 1'b0;
                        end
                    end else begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                close_next = (position_reg >= field_end_reg) || eop_reg;
                state_next = close_next ? ST_DONE : ST_IDLE;
                if (in_field) begin
                    if (byte_reg == CHAR_NUL) begin
                        close_next = 1'b1;
                        state_next = ST_DONE;
                    end else if (printable) begin
                        kept_next = kept_reg + KW'(1);
                        if (kept_next == KEPT_MAX) begin
                            close_next = 1'b1;
                            state_next = ST_DONE;
                        end
                        if (byte_reg == CHAR_SPACE) begin
                            if (started_reg && (pend_reg < PEND_MAX)) begin
                                pend_next = pend_reg + 6'd1;
                            end
                        end else begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
                if (position_reg < POS_MAX) begin
                    position_next = position_reg + 8'd1;
                end
            end
            ST_FLUSH: begin
                // one pending space per cycle while the output slot is free, dropped once the limit is hit
                if (pend_reg == 6'd0) begin
                    state_next = ST_CHAR;
                end else if (!room) begin
                    pend_next = 6'd0;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: CHAR_SPACE[6:0], char_valid: 1'b1,
                                     field_done: 1'b0, field_length: emitted_reg + 6'd1};
                    emitted_next = emitted_reg + 6'd1;
                    pend_next    = pend_reg - 6'd1;
                end
            end
            ST_CHAR: begin
                if (!room || out_free) begin
                    if (room) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{out_char: byte_reg[6:0], char_valid: 1'b1,
                                         field_done: 1'b0, field_length: emitted_reg + 6'd1};
                        emitted_next = emitted_reg + 6'd1;
                    end
                    started_next = 1'b1;
                    state_next   = close_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = '{out_char: 7'd0, char_valid: 1'b0,
                                      field_done: 1'b1, field_length: emitted_reg};
                    finished_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (eop_reg) begin
                        position_next = 8'd0;
                        kept_next     = '0;
                        pend_next     = 6'd0;
                        started_next  = 1'b0;
                        emitted_next  = 6'd0;
                        finished_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, counters, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            field_start_reg <= FIELD_START_RST;
            field_end_reg   <= FIELD_END_RST;
            dest_size_reg   <= DEST_SIZE_RST;
            position_reg    <= 8'd0;
            kept_reg        <= '0;
            pend_reg        <= 6'd0;
            started_reg     <= 1'b0;
            emitted_reg     <= 6'd0;
            finished_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            position_reg <= position_next;
            kept_reg     <= kept_next;
            pend_reg     <= pend_next;
            started_reg  <= started_next;
            emitted_reg  <= emitted_next;
            finished_reg <= finished_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_FIELD_START: field_start_reg <= cfg_data;
                    REG_FIELD_END:   field_end_reg   <= cfg_data;
                    REG_DEST_SIZE:   dest_size_reg   <= cfg_data[6:0];
                    default:         ;
                endcase
            end
        end
        byte_reg   <= byte_next;
        eop_reg    <= eop_next;
        close_reg  <= close_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- rtl/core/tafe_checker.sv -----
// ----------------------------------------------------------------------------
// tafe_checker
// Port-level checks on the result channel of the field extract unit.
// ----------------------------------------------------------------------------
module tafe_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input tafe_pkg::tafe_out_t m_data
);
    import tafe_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a character result never closes the field
    a_char_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.char_valid |-> !m_data.field_done)
        else $error("character and close on one result");

    // emitted characters are printable
    a_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.char_valid |->
            (m_data.out_char >= CHAR_SPACE[6:0]) && (m_data.out_char != CHAR_DEL[6:0]))
        else $error("non-printable character emitted");

    // a character result taken and directly followed by another has a length one higher
    a_length_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.char_valid ##1 m_valid && m_data.char_valid
            |-> m_data.field_length == $past(m_data.field_length) + 6'd1)
        else $error("field length did not step by one");

endmodule

bind trimmed_ascii_field_extract_unit tafe_checker u_tafe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trimmed ascii field extract unit. Byte streams
// are pushed through the input channel under random idling and back-pressure,
// a behavioural predictor of the field trimming works out the character and
// closing transactions for every accepted byte, and a checker compares every
// result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import tafe_pkg::*;

    localparam int DEPTH        = 64;
    localparam int IDLE_MAX     = 17;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 140;
    localparam int CALM_ITEMS   = 40;
    localparam int LONG_HOLD    = 300;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    tafe_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    tafe_out_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // predictor copy of the registers
    logic [7:0] win_start;
    logic [7:0] win_end;
    logic [6:0] cap_size;

    // predictor copy of the field state
    logic [7:0] pos_cnt;
    logic [5:0] kept_cnt;
    logic [5:0] space_backlog;
    logic [5:0] emit_cnt;
    logic       seen_visible;
    logic       field_closed;

    tafe_out_t expected_chars[$];
    int        fail_count    = 0;
    int        items_sent    = 0;
    int        long_hold_req = 0;
    int        cycle_count   = 0;
    bit        idling_on     = 1'b1;

    trimmed_ascii_field_extract_unit #(
        .SCRATCH_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // re-arm for a new payload
    task automatic clear_field();
        pos_cnt       = '0;
        kept_cnt      = '0;
        space_backlog = '0;
        emit_cnt      = '0;
        seen_visible  = 1'b0;
        field_closed  = 1'b0;
    endtask

    // characters allowed out: one less than capacity, capped by the length width
    function automatic logic [6:0] emit_limit();
        logic [6:0] lim;
        lim = (cap_size == 7'd0) ? 7'd0 : cap_size - 7'd1;
        if (lim > MAX_EMIT) lim = MAX_EMIT;
        return lim;
    endfunction

    task automatic push_char(input logic [6:0] ch);
        tafe_out_t r;
        if ({1'b0, emit_cnt} < emit_limit()) begin
            emit_cnt     = emit_cnt + 6'd1;
            r.out_char     = ch;
            r.char_valid   = 1'b1;
            r.field_done   = 1'b0;
            r.field_length = emit_cnt;
            expected_chars.push_back(r);
        end
    endtask

    // expected transactions caused by one accepted byte
    task automatic predict_field_chars(input tafe_in_t item);
        logic      closing;
        tafe_out_t r;
        closing = 1'b0;
        if (!field_closed) begin
            if (pos_cnt >= win_start && pos_cnt <= win_end && kept_cnt < DEPTH - 1) begin
                if (item.in_byte == CHAR_NUL) begin
                    closing = 1'b1;
                end else if (item.in_byte >= CHAR_SPACE && item.in_byte < CHAR_DEL) begin
                    kept_cnt = kept_cnt + 6'd1;
                    if (item.in_byte == CHAR_SPACE) begin
                        // leading spaces vanish, inner ones wait for a visible char
                        if (seen_visible && space_backlog < PEND_MAX)
                            space_backlog = space_backlog + 6'd1;
                    end else begin
                        while (space_backlog != 0) begin
                            push_char(7'(CHAR_SPACE));
                            space_backlog = space_backlog - 6'd1;
                        end
                        push_char(item.in_byte[6:0]);
                        seen_visible = 1'b1;
                    end
                    if (kept_cnt >= DEPTH - 1) closing = 1'b1;
                end
            end
            if (pos_cnt >= win_end || item.end_of_payload) closing = 1'b1;
            if (closing) begin
                field_closed   = 1'b1;
                r.out_char     = '0;
                r.char_valid   = 1'b0;
                r.field_done   = 1'b1;
                r.field_length = emit_cnt;
                expected_chars.push_back(r);
            end
            if (pos_cnt < POS_MAX) pos_cnt = pos_cnt + 8'd1;
        end
        if (item.end_of_payload) clear_field();
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // ready with random stall bursts, plus an occasional long hold-off
    initial begin : result_ready_driver
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (long_hold_req > 0) begin
                m_ready       = 1'b0;
                stall_left    = long_hold_req - 1;
                long_hold_req = 0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                m_ready    = 1'b0;
                stall_left = $urandom_range(1, IDLE_MAX) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        tafe_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected result: out_char %0d char_valid %0b field_done %0b length %0d",
                       m_data.out_char, m_data.char_valid, m_data.field_done,
                       m_data.field_length);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (m_data.out_char !== want.out_char) begin
                    $error("out_char: expected %0d, actual %0d", want.out_char, m_data.out_char);
                    fail_count++;
                end
                if (m_data.char_valid !== want.char_valid) begin
                    $error("char_valid: expected %0b, actual %0b",
                           want.char_valid, m_data.char_valid);
                    fail_count++;
                end
                if (m_data.field_done !== want.field_done) begin
                    $error("field_done: expected %0b, actual %0b",
                           want.field_done, m_data.field_done);
                    fail_count++;
                end
                if (m_data.field_length !== want.field_length) begin
                    $error("field_length: expected %0d, actual %0d",
                           want.field_length, m_data.field_length);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // offer one byte, with an optional idle burst first
    task automatic send_byte(input logic [7:0] b, input logic eop);
        tafe_in_t item;
        item.in_byte        = b;
        item.end_of_payload = eop;
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, IDLE_MAX)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        predict_field_chars(item);
        items_sent++;
    endtask

    task automatic send_text(input string txt, input bit eop_last);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], eop_last && (i == txt.len() - 1));
    endtask

    // byte mix: mostly visible characters and spaces, some noise, rare nul
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 8'($urandom_range(8'h21, 8'h7E));
        if (sel < 85) return CHAR_SPACE;
        if (sel < 97) return 8'($urandom_range(0, 255));
        return CHAR_NUL;
    endfunction

    task automatic send_payload(input int len, input bit eop_last);
        for (int i = 0; i < len; i++)
            send_byte(pick_byte(), eop_last && (i == len - 1));
    endtask

    // stop offering and wait for every predicted transaction, optionally settle
    task automatic await_results(input bit settle);
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_chars.size() != 0) @(negedge aclk);
        if (settle) repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FIELD_START: win_start = value;
            REG_FIELD_END:   win_end   = value;
            REG_DEST_SIZE:   cap_size  = value[6:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // reprogram the field window and capacity once the unit is quiet
    task automatic set_window(input logic [7:0] st, input logic [7:0] en,
                              input logic [7:0] size);
        await_results(1'b1);
        write_reg(REG_FIELD_START, st);
        write_reg(REG_FIELD_END, en);
        write_reg(REG_DEST_SIZE, size);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset window: leading, inner and trailing spaces
    task automatic test_reset_defaults();
        send_text(" a b ", 1'b1);
    endtask

    // bytes outside the window, control and high bytes, nul close, bytes after close
    task automatic test_nonprintable_and_nul();
        set_window(8'd1, 8'd6, 8'd32);
        send_byte("A", 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(CHAR_DEL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(CHAR_NUL, 1'b0);
        send_byte("B", 1'b0);
        send_byte("C", 1'b1);
    endtask

    // zero capacity, then a capacity that cuts the field short after the inner space
    task automatic test_capacity_limits();
        set_window(8'd0, 8'd29, 8'd0);
        send_text("ab", 1'b1);
        set_window(8'd0, 8'd29, 8'd3);
        send_text("a bcd", 1'b1);
    endtask

    // window end before its start closes the field empty
    task automatic test_end_before_start();
        set_window(8'd200, 8'd2, 8'd32);
        send_text("xyzw", 1'b1);
    endtask

    // a long printable payload fills the scratch and closes the field
    task automatic test_scratch_limit();
        set_window(8'd0, 8'd255, 8'd64);
        for (int i = 0; i < 70; i++)
            send_byte(($urandom_range(0, 3) == 0) ? CHAR_SPACE
                                                  : 8'($urandom_range(8'h21, 8'h7E)),
                      i == 69);
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_output_backpressure();
        set_window(8'd0, 8'd40, 8'd64);
        long_hold_req = LONG_HOLD;
        for (int i = 0; i < 25; i++)
            send_byte(8'($urandom_range(8'h21, 8'h7E)), i == 24);
    endtask

    // sender pauses mid-payload until everything has drained
    task automatic test_sender_pause();
        set_window(8'd2, 8'd30, 8'd40);
        send_text("  ab  cd", 1'b0);
        await_results(1'b0);
        send_text("  ef  ", 1'b1);
    endtask

    task automatic random_config();
        logic [7:0] st;
        logic [7:0] en;
        logic [7:0] size;
        case ($urandom_range(0, 5))
            0: begin
                st = 8'd0;
                en = 8'd255;
            end
            1: begin
                st = 8'd255;
                en = 8'd0;
            end
            2: begin
                st = 8'($urandom_range(0, 255));
                en = 8'($urandom_range(0, 255));
            end
            default: begin
                st = 8'($urandom_range(0, 6));
                en = st + 8'($urandom_range(0, 24));
            end
        endcase
        case ($urandom_range(0, 6))
            0: size = 8'd0;
            1: size = 8'hFF;
            2: size = 8'd64;
            3: size = 8'($urandom_range(0, 255));
            default: size = 8'($urandom_range(1, 20));
        endcase
        set_window(st, en, size);
    endtask

    // random payloads, mostly well formed, some without an end marker
    task automatic test_random_payloads();
        int base;
        int len;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (items_sent - base >= RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
            if ($urandom_range(0, 2) == 0) random_config();
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            send_payload(len, $urandom_range(0, 7) != 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        win_start = FIELD_START_RST;
        win_end   = FIELD_END_RST;
        cap_size  = DEST_SIZE_RST;
        clear_field();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_nonprintable_and_nul();
        test_capacity_limits();
        test_end_before_start();
        test_scratch_limit();
        test_output_backpressure();
        test_sender_pause();
        test_random_payloads();

        await_results(1'b1);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
